// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hw/rtl/tvsf_pkg.sv
// ----------------------------------------------------------------------------
// tvsf_pkg
// Types, codes and compare helpers for the typed value scan filter.
// ----------------------------------------------------------------------------
package tvsf_pkg;

    localparam int AddressBitsDefault = 48;
    localparam int ValueBits = 64;
    localparam int CountBits = 24;
    localparam int CfgIndexBits = 3;

    typedef enum logic [2:0] {
        VT_U8  = 3'd0,
        VT_S16 = 3'd1,
        VT_S32 = 3'd2,
        VT_S64 = 3'd3,
        VT_F32 = 3'd4,
        VT_F64 = 3'd5
    } t_value_type;

    typedef enum logic [3:0] {
        SM_EXACT     = 4'd0,
        SM_GREATER   = 4'd1,
        SM_LESS      = 4'd2,
        SM_BETWEEN   = 4'd3,
        SM_ANY       = 4'd4,
        SM_CHANGED   = 4'd5,
        SM_UNCHANGED = 4'd6,
        SM_INCREASED = 4'd7,
        SM_DECREASED = 4'd8
    } t_scan_mode;

    typedef enum logic [2:0] {
        CFG_VALUE_TYPE   = 3'd0,
        CFG_SCAN_MODE    = 3'd1,
        CFG_TARGET_LOW   = 3'd2,
        CFG_TARGET_HIGH  = 3'd3,
        CFG_RESULT_LIMIT = 3'd4
    } t_cfg_index;

    localparam logic [2:0] ResetValueType = 3'd2;
    localparam logic [3:0] ResetScanMode = 4'd0;
    localparam logic [CountBits-1:0] ResetResultLimit = 24'd65536;

    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } t_rel;

    typedef struct packed {
        logic [2:0]           value_type;
        logic [3:0]           scan_mode;
        logic [ValueBits-1:0] target_low;
        logic [ValueBits-1:0] target_high;
    } t_cfg;

    function automatic logic [ValueBits-1:0] size_mask(input logic [2:0] vt);
        logic [ValueBits-1:0] m;
        m = '0;
        unique case (vt)
            VT_U8:          m = 64'h0000_0000_0000_00FF;
            VT_S16:         m = 64'h0000_0000_0000_FFFF;
            VT_S32, VT_F32: m = 64'h0000_0000_FFFF_FFFF;
            VT_S64, VT_F64: m = '1;
            default:        m = '0;
        endcase
        return m;
    endfunction

    // Order key for a float: sign-magnitude mapped onto unsigned order.
    function automatic logic [ValueBits-1:0] fkey(input logic [ValueBits-1:0] v);
        return v[ValueBits-1] ? ~v : (v | {1'b1, {(ValueBits-1){1'b0}}});
    endfunction

    function automatic t_rel relate(input logic [2:0] vt,
                                    input logic [ValueBits-1:0] a,
                                    input logic [ValueBits-1:0] b);
        logic [ValueBits-1:0] ka;
        logic [ValueBits-1:0] kb;
        logic nan;
        logic zero;
        t_rel r;
        ka = '0;
        kb = '0;
        nan = 1'b0;
        zero = 1'b0;
        unique case (vt)
            VT_U8: begin
                ka = {56'd0, a[7:0]};
                kb = {56'd0, b[7:0]};
            end
            VT_S16: begin
                ka = {48'd0, ~a[15], a[14:0]};
                kb = {48'd0, ~b[15], b[14:0]};
            end
            VT_S32: begin
                ka = {32'd0, ~a[31], a[30:0]};
                kb = {32'd0, ~b[31], b[30:0]};
            end
            VT_S64: begin
                ka = {~a[63], a[62:0]};
                kb = {~b[63], b[62:0]};
            end
            VT_F32: begin
                ka = fkey({a[31:0], 32'd0});
                kb = fkey({b[31:0], 32'd0});
                nan = (&a[30:23] && |a[22:0]) || (&b[30:23] && |b[22:0]);
                zero = (a[30:0] == '0) && (b[30:0] == '0);
            end
            VT_F64: begin
                ka = fkey(a);
                kb = fkey(b);
                nan = (&a[62:52] && |a[51:0]) || (&b[62:52] && |b[51:0]);
                zero = (a[62:0] == '0) && (b[62:0] == '0);
            end
            default: nan = 1'b1;
        endcase
        if (nan) begin
            r = '0;
        end else if (zero) begin
            r = '{lt: 1'b0, eq: 1'b1, gt: 1'b0};
        end else begin
            r = '{lt: ka < kb, eq: ka == kb, gt: ka > kb};
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/tvsf_compare.sv
// ----------------------------------------------------------------------------
// tvsf_compare
// Typed compare of one candidate under the configured scan mode.
// ----------------------------------------------------------------------------
module tvsf_compare
    import tvsf_pkg::*;
(
    input  t_cfg                 i_cfg,
    input  logic [ValueBits-1:0] i_cur,
    input  logic [ValueBits-1:0] i_prev,
    input  logic                 i_has_prev,
    output logic                 o_match
);

    t_rel rel_lo;
    t_rel rel_hi;
    t_rel rel_pv;

    assign rel_lo = relate(i_cfg.value_type, i_cur, i_cfg.target_low);
    assign rel_hi = relate(i_cfg.value_type, i_cur, i_cfg.target_high);
    assign rel_pv = relate(i_cfg.value_type, i_cur, i_prev);

    always_comb begin
        o_match = 1'b0;
        if (i_cfg.value_type <= VT_F64) begin
            unique case (i_cfg.scan_mode)
                SM_EXACT:     o_match = rel_lo.eq;
                SM_GREATER:   o_match = rel_lo.gt;
                SM_LESS:      o_match = rel_lo.lt;
                SM_BETWEEN:   o_match = (rel_lo.gt | rel_lo.eq) & (rel_hi.lt | rel_hi.eq);
                SM_ANY:       o_match = 1'b1;
                SM_CHANGED:   o_match = i_has_prev & ~rel_pv.eq;
                SM_UNCHANGED: o_match = i_has_prev & rel_pv.eq;
                SM_INCREASED: o_match = i_has_prev & rel_pv.gt;
                SM_DECREASED: o_match = i_has_prev & rel_pv.lt;
                default:      o_match = 1'b0;
            endcase
        end
    end

endmodule

// File: hw/rtl/typed_value_scan_filter.sv
// An accepted input word enters the input register; a match moves on to the
// result register. Throughput: one input word per cycle while the result
// slot is free or draining; compare and count logic sit between the two.
// Reset (i_rst_n low, synchronous): pipeline empty, match count zero,
// registers at value_type 2, scan_mode 0, targets 0, result_limit 65536.
// ----------------------------------------------------------------------------
// typed_value_scan_filter
// Filters memory candidates by typed compare; emits matches up to a limit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module typed_value_scan_filter
    import tvsf_pkg::*;
#(
    parameter int ADDRESS_BITS = AddressBitsDefault
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [ADDRESS_BITS-1:0] i_address,
    input  logic [ValueBits-1:0]    i_current_value,
    input  logic [ValueBits-1:0]    i_previous_value,
    input  logic                    i_has_previous,
    input  logic                    i_starts_scan,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [ADDRESS_BITS-1:0] o_match_address,
    output logic [ValueBits-1:0]    o_match_value,
    output logic [ValueBits-1:0]    o_match_previous,
    output logic                    o_limit_hit,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CfgIndexBits-1:0] i_cfg_index,
    input  logic [ValueBits-1:0]    i_cfg_data
);

    t_cfg                  r_cfg;
    logic [CountBits-1:0]  r_limit;
    logic [CountBits-1:0]  r_count;
    logic [CountBits-1:0]  n_count;

    logic                    r_in_valid;
    logic [ADDRESS_BITS-1:0] r_in_addr;
    logic [ValueBits-1:0]    r_in_cur;
    logic [ValueBits-1:0]    r_in_prev;
    logic                    r_in_has_prev;
    logic                    r_in_start;

    logic                    r_out_valid;
    logic [ADDRESS_BITS-1:0] r_out_addr;
    logic [ValueBits-1:0]    r_out_value;
    logic [ValueBits-1:0]    r_out_prev;
    logic                    r_out_hit;

    logic                    match;
    logic [CountBits-1:0]    base_count;
    logic                    emit;
    logic                    advance;
    logic [ValueBits-1:0]    mask;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.value_type  <= ResetValueType;
            r_cfg.scan_mode   <= ResetScanMode;
            r_cfg.target_low  <= '0;
            r_cfg.target_high <= '0;
            r_limit           <= ResetResultLimit;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VALUE_TYPE:   r_cfg.value_type  <= i_cfg_data[2:0];
                CFG_SCAN_MODE:    r_cfg.scan_mode   <= i_cfg_data[3:0];
                CFG_TARGET_LOW:   r_cfg.target_low  <= i_cfg_data;
                CFG_TARGET_HIGH:  r_cfg.target_high <= i_cfg_data;
                CFG_RESULT_LIMIT: r_limit <= i_cfg_data[CountBits-1:0];
                default: ;
            endcase
        end
    end

    tvsf_compare u_compare (
        .i_cfg      (r_cfg),
        .i_cur      (r_in_cur),
        .i_prev     (r_in_prev),
        .i_has_prev (r_in_has_prev),
        .o_match    (match)
    );

    // Stage 2 advances when the result slot is free or being drained.
    assign advance = ~r_out_valid | i_ready;
    assign o_ready = ~r_in_valid | advance;
    assign base_count = r_in_start ? '0 : r_count;
    assign emit = r_in_valid & match & (base_count < r_limit);
    assign n_count = emit ? base_count + 1'b1 : base_count;
    assign mask = size_mask(r_cfg.value_type);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= emit;
                if (r_in_valid) begin
                    r_count <= n_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_addr     <= i_address;
            r_in_cur      <= i_current_value;
            r_in_prev     <= i_previous_value;
            r_in_has_prev <= i_has_previous;
            r_in_start    <= i_starts_scan;
        end
        if (advance && emit) begin
            r_out_addr  <= r_in_addr;
            r_out_value <= r_in_cur & mask;
            r_out_prev  <= (r_in_has_prev ? r_in_prev : r_in_cur) & mask;
            r_out_hit   <= (n_count == r_limit);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_match_address  = r_out_addr;
    assign o_match_value    = r_out_value;
    assign o_match_previous = r_out_prev;
    assign o_limit_hit      = r_out_hit;

    `ASSERT_CLK(a_count_step, i_clk, i_rst_n,
        (advance && emit) |=> (r_count == $past(base_count) + 1'b1),
        "match count did not step on an emitted match")
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out_addr)),
        "stalled result changed")
    `ASSERT_CLK(a_no_emit_over, i_clk, i_rst_n,
        emit |-> (n_count <= r_limit),
        "match emitted beyond limit")
    `ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> (!r_out_valid && !r_in_valid),
        "pipeline not empty after reset")

endmodule

// File: verif/tb_typed_value_scan_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_typed_value_scan_filter
// Drives candidate words through the scan filter with a local model of the
// typed compares and the per-scan match limit, and checks every match word
// against it in order. Directed cases first, then random scans under varied
// settings and idle patterns, including a long output hold-off.
// ----------------------------------------------------------------------------
module tb_typed_value_scan_filter
    import tvsf_pkg::*;
();

    typedef struct {
        logic [47:0] addr;
        logic [63:0] value;
        logic [63:0] previous;
        logic        hit;
    } t_match;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [47:0] i_address = '0;
    logic [63:0] i_current_value = '0;
    logic [63:0] i_previous_value = '0;
    logic        i_has_previous = 1'b0;
    logic        i_starts_scan = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [47:0] o_match_address;
    logic [63:0] o_match_value;
    logic [63:0] o_match_previous;
    logic        o_limit_hit;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    // model registers
    logic [2:0]  m_type = 3'd2;
    logic [3:0]  m_mode = 4'd0;
    logic [63:0] m_low = '0;
    logic [63:0] m_high = '0;
    logic [23:0] m_limit = 24'd65536;
    logic [23:0] m_count = '0;

    t_match pending_matches[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;

    typed_value_scan_filter u_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [63:0] type_mask(input logic [2:0] vt);
        case (vt)
            VT_U8:          return 64'hFF;
            VT_S16:         return 64'hFFFF;
            VT_S32, VT_F32: return 64'hFFFF_FFFF;
            VT_S64, VT_F64: return '1;
            default:        return '0;
        endcase
    endfunction

    function automatic t_rel float_order(input logic sa, input logic [62:0] ma,
                                         input logic sb, input logic [62:0] mb,
                                         input logic any_nan);
        t_rel r;
        r = '0;
        if (any_nan) return r;
        if (ma == 0 && mb == 0) r.eq = 1'b1;
        else if (sa != sb) begin
            r.lt = sa;
            r.gt = sb;
        end else if (ma == mb) r.eq = 1'b1;
        else if (!sa) begin
            r.lt = ma < mb;
            r.gt = ma > mb;
        end else begin
            r.lt = ma > mb;
            r.gt = ma < mb;
        end
        return r;
    endfunction

    function automatic t_rel typed_order(input logic [2:0] vt, input logic [63:0] a,
                                         input logic [63:0] b);
        t_rel r;
        r = '0;
        case (vt)
            VT_U8: r = '{lt: a[7:0] < b[7:0], eq: a[7:0] == b[7:0], gt: a[7:0] > b[7:0]};
            VT_S16: r = '{lt: $signed(a[15:0]) < $signed(b[15:0]),
                          eq: a[15:0] == b[15:0],
                          gt: $signed(a[15:0]) > $signed(b[15:0])};
            VT_S32: r = '{lt: $signed(a[31:0]) < $signed(b[31:0]),
                          eq: a[31:0] == b[31:0],
                          gt: $signed(a[31:0]) > $signed(b[31:0])};
            VT_S64: r = '{lt: $signed(a) < $signed(b), eq: a == b,
                          gt: $signed(a) > $signed(b)};
            VT_F32: r = float_order(a[31], {32'd0, a[30:0]}, b[31], {32'd0, b[30:0]},
                                    (&a[30:23] && |a[22:0]) || (&b[30:23] && |b[22:0]));
            VT_F64: r = float_order(a[63], a[62:0], b[63], b[62:0],
                                    (&a[62:52] && |a[51:0]) || (&b[62:52] && |b[51:0]));
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic passes_scan(input logic [63:0] cur, input logic [63:0] prev,
                                         input logic hp);
        t_rel rt;
        t_rel rh;
        t_rel rp;
        if (m_type > VT_F64) return 1'b0;
        rt = typed_order(m_type, cur, m_low);
        rh = typed_order(m_type, cur, m_high);
        rp = typed_order(m_type, cur, prev);
        case (m_mode)
            SM_EXACT:     return rt.eq;
            SM_GREATER:   return rt.gt;
            SM_LESS:      return rt.lt;
            SM_BETWEEN:   return (rt.gt || rt.eq) && (rh.lt || rh.eq);
            SM_ANY:       return 1'b1;
            SM_CHANGED:   return hp && !rp.eq;
            SM_UNCHANGED: return hp && rp.eq;
            SM_INCREASED: return hp && rp.gt;
            SM_DECREASED: return hp && rp.lt;
            default:      return 1'b0;
        endcase
    endfunction

    task automatic predict_match(input logic [47:0] addr, input logic [63:0] cur,
                                 input logic [63:0] prev, input logic hp, input logic ss);
        t_match m;
        logic [63:0] mask;
        if (ss) m_count = '0;
        if (passes_scan(cur, prev, hp) && m_count < m_limit) begin
            m_count = m_count + 1'b1;
            mask = type_mask(m_type);
            m.addr = addr;
            m.value = cur & mask;
            m.previous = (hp ? prev : cur) & mask;
            m.hit = (m_count == m_limit);
            pending_matches = {pending_matches, m};
        end
    endtask

    // accepted words: model update
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_VALUE_TYPE:   m_type = i_cfg_data[2:0];
                CFG_SCAN_MODE:    m_mode = i_cfg_data[3:0];
                CFG_TARGET_LOW:   m_low = i_cfg_data;
                CFG_TARGET_HIGH:  m_high = i_cfg_data;
                CFG_RESULT_LIMIT: m_limit = i_cfg_data[23:0];
                default: ;
            endcase
        end
        if (i_rst_n && i_valid && o_ready)
            predict_match(i_address, i_current_value, i_previous_value,
                          i_has_previous, i_starts_scan);
    end

    // result checker
    always @(posedge i_clk) begin
        t_match m;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_matches.size() == 0) begin
                errors++;
                $display("%0t: match word exp none got addr %h", $time, o_match_address);
            end else begin
                m = pending_matches.pop_front();
                if (o_match_address !== m.addr) begin
                    errors++;
                    $display("%0t: address exp %h got %h", $time, m.addr, o_match_address);
                end
                if (o_match_value !== m.value) begin
                    errors++;
                    $display("%0t: value exp %h got %h", $time, m.value, o_match_value);
                end
                if (o_match_previous !== m.previous) begin
                    errors++;
                    $display("%0t: previous exp %h got %h", $time, m.previous,
                             o_match_previous);
                end
                if (o_limit_hit !== m.hit) begin
                    errors++;
                    $display("%0t: limit_hit exp %b got %b", $time, m.hit, o_limit_hit);
                end
            end
        end
    end

    // receiver: random stalls plus a counted hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_word(input logic [47:0] addr, input logic [63:0] cur,
                             input logic [63:0] prev, input logic hp, input logic ss);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_address <= addr;
        i_current_value <= cur;
        i_previous_value <= prev;
        i_has_previous <= hp;
        i_starts_scan <= ss;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // settings change only with the block drained
    task automatic cfg_write(input t_cfg_index idx, input logic [63:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] wide_rand();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] special_value(input logic [2:0] vt);
        logic [63:0] mask;
        mask = type_mask(vt);
        if (vt == VT_F32) begin
            case ($urandom_range(9))
                0: return 64'h0000_0000;
                1: return 64'h8000_0000;
                2: return 64'h3F80_0000;
                3: return 64'hBF80_0000;
                4: return 64'h4000_0000;
                5: return 64'h7F80_0000;
                6: return 64'hFF80_0000;
                7: return 64'h7FC0_0000;
                8: return 64'h0000_0001;
                default: return 64'h3F80_0001;
            endcase
        end
        if (vt == VT_F64) begin
            case ($urandom_range(9))
                0: return 64'h0;
                1: return 64'h8000_0000_0000_0000;
                2: return $realtobits(1.0);
                3: return $realtobits(-1.0);
                4: return $realtobits(2.0);
                5: return 64'h7FF0_0000_0000_0000;
                6: return 64'hFFF0_0000_0000_0000;
                7: return 64'h7FF8_0000_0000_0000;
                8: return 64'h1;
                default: return $realtobits(-0.5);
            endcase
        end
        case ($urandom_range(4))
            0: return 64'h0;
            1: return mask;
            2: return mask >> 1;
            3: return (mask >> 1) + 1;
            default: return 64'(signed'($urandom_range(0, 8)) - 4);
        endcase
    endfunction

    function automatic logic [63:0] pick_value(input logic [2:0] vt, input logic [63:0] near);
        logic [63:0] v;
        logic [63:0] mask;
        mask = type_mask(vt);
        case ($urandom_range(9))
            0, 1: v = m_low;
            2:    v = m_high;
            3, 4: v = near + 64'(signed'($urandom_range(0, 2)) - 1);
            5, 6: v = special_value(vt);
            default: v = wide_rand();
        endcase
        if ($urandom_range(3) == 0) v = (v & mask) | (wide_rand() & ~mask);
        return v;
    endfunction

    task automatic random_settings();
        logic [2:0]  vt;
        logic [63:0] lo;
        vt = ($urandom_range(9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        lo = special_value(vt);
        cfg_write(CFG_VALUE_TYPE, {61'd0, vt});
        cfg_write(CFG_SCAN_MODE, ($urandom_range(9) == 0) ? 64'($urandom_range(9, 15))
                                                           : 64'($urandom_range(0, 8)));
        cfg_write(CFG_TARGET_LOW, lo);
        cfg_write(CFG_TARGET_HIGH, ($urandom_range(2) == 0) ? special_value(vt)
                                                             : lo + $urandom_range(0, 50));
        case ($urandom_range(5))
            0: cfg_write(CFG_RESULT_LIMIT, 64'd0);
            1: cfg_write(CFG_RESULT_LIMIT, 64'hFF_FFFF);
            2: cfg_write(CFG_RESULT_LIMIT, 64'($urandom_range(1, 4)));
            default: cfg_write(CFG_RESULT_LIMIT, 64'($urandom_range(5, 60)));
        endcase
    endtask

    task automatic test_reset_defaults();
        send_word(48'h0, 64'h0, 64'h0, 1'b0, 1'b1);
        send_word('1, 64'hFFFF_FFFF_0000_0000, 64'h5, 1'b1, 1'b0);
        send_word(48'h1234, 64'h1, 64'h0, 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_special_cases();
        cfg_write(CFG_VALUE_TYPE, 64'(VT_U8));
        cfg_write(CFG_TARGET_LOW, 64'hFF);
        send_word(48'h10, 64'hAAAA_00FF, 64'h1234_5678, 1'b1, 1'b1);
        send_word(48'h11, 64'h0, 64'h0, 1'b1, 1'b0);
        cfg_write(CFG_VALUE_TYPE, 64'(VT_S16));
        cfg_write(CFG_SCAN_MODE, 64'(SM_GREATER));
        cfg_write(CFG_TARGET_LOW, 64'h0);
        send_word(48'h20, 64'h8000, 64'h0, 1'b0, 1'b0);
        send_word(48'h21, 64'h7FFF, 64'h0, 1'b0, 1'b0);
        cfg_write(CFG_VALUE_TYPE, 64'(VT_S64));
        cfg_write(CFG_SCAN_MODE, 64'(SM_LESS));
        send_word(48'h30, 64'h8000_0000_0000_0000, 64'h0, 1'b0, 1'b0);
        send_word(48'h31, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 1'b0);
        cfg_write(CFG_VALUE_TYPE, 64'(VT_F32));
        cfg_write(CFG_SCAN_MODE, 64'(SM_EXACT));
        send_word(48'h40, 64'h8000_0000, 64'h0, 1'b0, 1'b0);
        send_word(48'h41, 64'h7FC0_0000, 64'h0, 1'b0, 1'b0);
        cfg_write(CFG_VALUE_TYPE, 64'(VT_F64));
        cfg_write(CFG_SCAN_MODE, 64'(SM_BETWEEN));
        cfg_write(CFG_TARGET_LOW, $realtobits(-1.0));
        cfg_write(CFG_TARGET_HIGH, $realtobits(1.0));
        send_word(48'h50, $realtobits(0.5), 64'h0, 1'b0, 1'b0);
        send_word(48'h51, 64'h7FF8_0000_0000_0000, 64'h0, 1'b0, 1'b0);
        send_word(48'h52, 64'h7FF0_0000_0000_0000, 64'h0, 1'b0, 1'b0);
        // low above high
        cfg_write(CFG_TARGET_LOW, $realtobits(1.0));
        cfg_write(CFG_TARGET_HIGH, $realtobits(-1.0));
        send_word(48'h53, $realtobits(0.0), 64'h0, 1'b0, 1'b0);
        cfg_write(CFG_SCAN_MODE, 64'(SM_ANY));
        send_word(48'h60, 64'h1, 64'h2, 1'b0, 1'b0);
        cfg_write(CFG_SCAN_MODE, 64'(SM_CHANGED));
        send_word(48'h70, $realtobits(1.0), 64'h7FF8_0000_0000_0001, 1'b1, 1'b0);
        send_word(48'h71, $realtobits(1.0), $realtobits(2.0), 1'b0, 1'b0);
        cfg_write(CFG_SCAN_MODE, 64'(SM_UNCHANGED));
        send_word(48'h72, 64'h0, 64'h8000_0000_0000_0000, 1'b1, 1'b0);
        cfg_write(CFG_SCAN_MODE, 64'(SM_INCREASED));
        send_word(48'h73, $realtobits(2.0), $realtobits(1.0), 1'b1, 1'b0);
        cfg_write(CFG_SCAN_MODE, 64'(SM_DECREASED));
        send_word(48'h74, $realtobits(-2.0), $realtobits(1.0), 1'b1, 1'b0);
        cfg_write(CFG_SCAN_MODE, 64'd9);
        send_word(48'h80, 64'h0, 64'h0, 1'b1, 1'b0);
        cfg_write(CFG_SCAN_MODE, 64'(SM_ANY));
        cfg_write(CFG_VALUE_TYPE, 64'd6);
        send_word(48'h81, 64'h0, 64'h0, 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_match_limit();
        cfg_write(CFG_VALUE_TYPE, 64'(VT_S32));
        cfg_write(CFG_SCAN_MODE, 64'(SM_ANY));
        cfg_write(CFG_RESULT_LIMIT, 64'd2);
        for (int k = 0; k < 4; k++) send_word(48'(k), wide_rand(), wide_rand(), 1'b1, k == 0);
        send_word(48'h9, 64'h9, 64'h0, 1'b0, 1'b1);
        wait_idle();
        cfg_write(CFG_RESULT_LIMIT, 64'd0);
        send_word(48'hA, 64'h1, 64'h0, 1'b0, 1'b1);
        wait_idle();
        cfg_write(CFG_RESULT_LIMIT, 64'd10);
        for (int k = 0; k < 3; k++) send_word(48'(k), wide_rand(), 64'h0, 1'b0, k == 0);
        wait_idle();
        // limit lowered below the count mid-scan
        cfg_write(CFG_RESULT_LIMIT, 64'd2);
        send_word(48'hB, 64'h1, 64'h0, 1'b0, 1'b0);
        wait_idle();
        cfg_write(CFG_RESULT_LIMIT, 64'hFF_FFFF);
        send_word('1, '1, 64'h0, 1'b0, 1'b1);
        wait_idle();
    endtask

    task automatic random_scan(input int n);
        logic [63:0] cur;
        logic [63:0] prev;
        for (int k = 0; k < n; k++) begin
            prev = pick_value(m_type, m_low);
            cur = pick_value(m_type, prev);
            send_word(($urandom_range(19) == 0) ? 48'h0 : 48'(wide_rand()), cur, prev,
                      $urandom_range(4) != 0, $urandom_range(24) == 0);
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        cfg_write(CFG_SCAN_MODE, 64'(SM_ANY));
        cfg_write(CFG_VALUE_TYPE, 64'(VT_U8));
        cfg_write(CFG_RESULT_LIMIT, 64'hFF_FFFF);
        @(posedge i_clk);
        hold_left = 80;
        random_scan(40);
        wait_idle();
    endtask

    task automatic test_random_phase(input int n_items, input int s_pct, input int r_pct);
        int done;
        int chunk;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        done = 0;
        while (done < n_items) begin
            random_settings();
            chunk = $urandom_range(30, 90);
            random_scan(chunk);
            done += chunk;
            wait_idle();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_special_cases();
        test_match_limit();
        test_random_phase(400, 32, 52);
        test_backpressure();
        test_random_phase(400, 52, 32);
        test_random_phase(400, 0, 0);
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/tvsf_pkg.sv
hw/rtl/tvsf_compare.sv
hw/rtl/typed_value_scan_filter.sv
verif/tb_typed_value_scan_filter.sv
